FILE: sv/tmtc_pkg.sv
// Shared types and constants for the tempo map tick/time converter.
// No dependencies.
package tmtc_pkg;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_T2US   = 2'd2;
  localparam logic [1:0] OP_US2T   = 2'd3;

  localparam logic [17:0] DEFAULT_BPM_RAW = 18'd30720;  // 120.0 bpm in UQ10.8
  localparam logic [25:0] US_PER_MINUTE   = 26'd60000000;
  localparam logic [62:0] SAT63           = {63{1'b1}};

  typedef logic [62:0] us_t;
  typedef logic [30:0] tick_t;

endpackage

FILE: sv/tempo_map_tick_time_convert_top.sv
// Tempo map tick/time converter, top level.
// Op 0/1 go straight to the result; op 2 runs one segment per table entry at or below the
// tick plus one for the last segment, each through the 65-step divider; op 3 repeats that
// for each of up to 31 binary search steps. One word in flight at a time.
// Reset (rst_n, synchronous, active low) empties the table and zeroes song_length;
// table memory contents are left as they are.
module tempo_map_tick_time_convert_top import tmtc_pkg::*; #(
  parameter int MAX_TEMPO_CHANGES = 64,
  parameter int TICKS_PER_QUARTER = 480
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [30:0]  cfg_wr_data,     // song_length
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [119:0] in_tdata,        // event_tick[31:0], tempo_bpm[49:32], time_us[113:50]
  input  logic [1:0]   in_tuser,        // op
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,       // result_us[62:0], result_tick[93:63]
  output logic         out_tuser        // table_full
);

  localparam int AW = $clog2(MAX_TEMPO_CHANGES > 1 ? MAX_TEMPO_CHANGES : 2);
  localparam int CW = $clog2(MAX_TEMPO_CHANGES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TEMPO_CHANGES);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_SEG  = 3'd3;
  localparam logic [2:0] ST_SRCH = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]    state_r, state_nxt;
  tick_t         song_len_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [63:0]   tus_r, tus_nxt;
  tick_t         t_r, t_nxt;
  tick_t         cur_r, cur_nxt;
  tick_t         lo_r, lo_nxt, hi_r, hi_nxt;
  logic [17:0]   bpm_r, bpm_nxt, nbpm_r, nbpm_nxt;
  us_t           total_r, total_nxt;
  logic          final_r, final_nxt;
  us_t           res_us_r, res_us_nxt;
  tick_t         res_tick_r, res_tick_nxt;
  logic          full_r, full_nxt;
  logic          out_valid_r;
  us_t           out_us_r;
  tick_t         out_tick_r;
  logic          out_full_r;

  logic          ram_we;
  logic [49:0]   ram_rdata;
  logic          seg_start, seg_done;
  tick_t         seg_dt;
  logic [17:0]   seg_bpm;
  us_t           seg_us;

  logic [31:0]   in_tick;
  logic [17:0]   in_bpm;
  logic [63:0]   in_tus;
  logic          in_fire;
  logic signed [31:0] ct;
  tick_t         mid;
  logic [63:0]   sum;

  assign in_tick = in_tdata[31:0];
  assign in_bpm  = in_tdata[49:32];
  assign in_tus  = in_tdata[113:50];
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign ram_we    = in_fire && in_tuser == OP_APPEND && cnt_r < MAX_CNT;

  assign ct  = $signed(ram_rdata[31:0]);
  assign mid = lo_r + ((hi_r - lo_r) >> 1);
  assign sum = {1'b0, total_r} + {1'b0, seg_us};

  tmtc_ram #(.WIDTH(50), .DEPTH(MAX_TEMPO_CHANGES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata ({in_bpm, in_tick}),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  tmtc_seg_unit #(.TICKS_PER_QUARTER(TICKS_PER_QUARTER)) u_seg (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (seg_start),
    .dt     (seg_dt),
    .bpm    (seg_bpm),
    .done   (seg_done),
    .seg_us (seg_us)
  );

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    op_nxt       = op_r;
    tus_nxt      = tus_r;
    t_nxt        = t_r;
    cur_nxt      = cur_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    bpm_nxt      = bpm_r;
    nbpm_nxt     = nbpm_r;
    total_nxt    = total_r;
    final_nxt    = final_r;
    res_us_nxt   = res_us_r;
    res_tick_nxt = res_tick_r;
    full_nxt     = full_r;
    seg_start    = 1'b0;
    seg_dt       = t_r - cur_r;
    seg_bpm      = bpm_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          op_nxt       = in_tuser;
          tus_nxt      = in_tus;
          res_us_nxt   = '0;
          res_tick_nxt = '0;
          full_nxt     = 1'b0;
          idx_nxt      = '0;
          cur_nxt      = '0;
          bpm_nxt      = DEFAULT_BPM_RAW;
          total_nxt    = '0;
          unique case (in_tuser)
            OP_CLEAR: begin
              cnt_nxt   = '0;
              state_nxt = ST_DONE;
            end
            OP_APPEND: begin
              if (cnt_r < MAX_CNT) cnt_nxt = cnt_r + 1'b1;
              else full_nxt = 1'b1;
              state_nxt = ST_DONE;
            end
            OP_T2US: begin
              if (in_tick[31]) t_nxt = '0;
              else if (in_tick[30:0] > song_len_r) t_nxt = song_len_r;
              else t_nxt = in_tick[30:0];
              state_nxt = ST_RD;
            end
            OP_US2T: begin
              lo_nxt = '0;
              hi_nxt = song_len_r;
              if (!in_tus[63] && in_tus != 64'd0) state_nxt = ST_SRCH;
              else state_nxt = ST_DONE;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SRCH: begin
        if (lo_r < hi_r) begin
          t_nxt     = mid;
          idx_nxt   = '0;
          cur_nxt   = '0;
          bpm_nxt   = DEFAULT_BPM_RAW;
          total_nxt = '0;
          state_nxt = ST_RD;
        end else begin
          res_tick_nxt = lo_r;
          state_nxt    = ST_DONE;
        end
      end
      ST_RD: begin
        if (idx_r < cnt_r) begin
          state_nxt = ST_CHK;
        end else begin
          // past the table: last segment up to the target tick
          seg_start = 1'b1;
          final_nxt = 1'b1;
          state_nxt = ST_SEG;
        end
      end
      ST_CHK: begin
        seg_start = 1'b1;
        state_nxt = ST_SEG;
        if (ct > $signed({1'b0, t_r})) begin
          final_nxt = 1'b1;
        end else begin
          final_nxt = 1'b0;
          // entries below the cursor add no time but still set tempo
          if (ct < $signed({1'b0, cur_r})) begin
            seg_dt = '0;
          end else begin
            seg_dt  = ct[30:0] - cur_r;
            cur_nxt = ct[30:0];
          end
          nbpm_nxt = (ram_rdata[49:32] != 18'd0) ? ram_rdata[49:32] : bpm_r;
        end
      end
      ST_SEG: begin
        if (seg_done) begin
          total_nxt = sum[63] ? SAT63 : sum[62:0];
          if (final_r) begin
            if (op_r == OP_T2US) begin
              res_us_nxt = sum[63] ? SAT63 : sum[62:0];
              state_nxt  = ST_DONE;
            end else begin
              if ({1'b0, (sum[63] ? SAT63 : sum[62:0])} < tus_r) lo_nxt = t_r + 31'd1;
              else hi_nxt = t_r;
              state_nxt = ST_SRCH;
            end
          end else begin
            bpm_nxt   = nbpm_r;
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_RD;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      song_len_r  <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_wr_en) song_len_r <= cfg_wr_data;
      if (state_r == ST_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    idx_r      <= idx_nxt;
    op_r       <= op_nxt;
    tus_r      <= tus_nxt;
    t_r        <= t_nxt;
    cur_r      <= cur_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    bpm_r      <= bpm_nxt;
    nbpm_r     <= nbpm_nxt;
    total_r    <= total_nxt;
    final_r    <= final_nxt;
    res_us_r   <= res_us_nxt;
    res_tick_r <= res_tick_nxt;
    full_r     <= full_nxt;
    if (state_r == ST_DONE && (!out_valid_r || out_tready)) begin
      out_us_r   <= res_us_r;
      out_tick_r <= res_tick_r;
      out_full_r <= full_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_tick_r, out_us_r};
  assign out_tuser  = out_full_r;

  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> cnt_r < MAX_CNT) else $error("table write past capacity");
  a_seg_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    seg_done |-> state_r == ST_SEG) else $error("segment result outside wait state");
  a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SRCH |-> lo_r <= hi_r) else $error("search bounds crossed");
  a_cursor_le_target: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RD |-> cur_r <= t_r) else $error("cursor beyond target tick");

endmodule

FILE: sv/tmtc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tmtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/tmtc_seg_unit.sv
// Segment duration unit: floor(dt * 60e6 * 256 / (bpm * TPQ)), saturated to 63 bits.
// Two multipliers in one registered stage, then a 65-step restoring divider.
// Depends on tmtc_pkg.
module tmtc_seg_unit import tmtc_pkg::*; #(
  parameter int TICKS_PER_QUARTER = 480
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [30:0] dt,
  input  logic [17:0] bpm,
  output logic        done,
  output us_t         seg_us
);

  localparam logic [1:0] SU_IDLE = 2'd0;
  localparam logic [1:0] SU_MUL  = 2'd1;
  localparam logic [1:0] SU_DIV  = 2'd2;
  localparam logic [15:0] TPQ = 16'(TICKS_PER_QUARTER);

  logic [1:0]  state_r, state_nxt;
  logic [30:0] dt_r;
  logic [17:0] bpm_r;
  logic [64:0] num_r, num_nxt;   // dividend, quotient shifts in from the bottom
  logic [33:0] den_r, den_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [34:0] rem_sh;
  logic [56:0] prod;

  assign prod   = dt_r * US_PER_MINUTE;
  assign rem_sh = {rem_r, num_r[64]};

  always_comb begin
    state_nxt = state_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      SU_IDLE: begin
        if (start) state_nxt = SU_MUL;
      end
      SU_MUL: begin
        num_nxt   = {prod, 8'd0};
        den_nxt   = bpm_r * TPQ;
        rem_nxt   = '0;
        cnt_nxt   = 7'd0;
        state_nxt = SU_DIV;
      end
      SU_DIV: begin
        if (rem_sh >= {1'b0, den_r}) begin
          rem_nxt = 34'(rem_sh - {1'b0, den_r});
          num_nxt = {num_r[63:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[33:0];
          num_nxt = {num_r[63:0], 1'b0};
        end
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd64) begin
          done_nxt  = 1'b1;
          state_nxt = SU_IDLE;
        end
      end
      default: state_nxt = SU_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SU_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    if (start && state_r == SU_IDLE) begin
      dt_r  <= dt;
      bpm_r <= bpm;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done   = done_r;
  assign seg_us = (num_r[64:63] != 2'b00) ? SAT63 : num_r[62:0];

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for tempo_map_tick_time_convert_top.
// Depends on tmtc_pkg and the top level; the expected results come from a scoreboard class
// that keeps its own copy of the tempo table and the song length.
module testbench;
  import tmtc_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int TPQ         = 480;
  localparam longint CYCLE_LIMIT = 6000000;

  typedef struct packed {
    us_t   us;
    tick_t tk;
    logic  full;
  } tempo_result_t;

  class tempo_map_checker;
    int             fails;
    logic [30:0]    song_len;
    logic [31:0]    chg_tick [TABLE_DEPTH];
    logic [17:0]    chg_bpm [TABLE_DEPTH];
    int             chg_count;
    tempo_result_t  pending[$];

    function new();
      fails = 0;
      song_len = '0;
      chg_count = 0;
    endfunction

    function us_t seg_us(longint unsigned dt, logic [17:0] bpm);
      logic [127:0] num;
      logic [127:0] den;
      logic [127:0] q;
      num = 128'(dt) * 128'd60000000 * 128'd256;
      den = 128'(bpm) * 128'(TPQ);
      q = num / den;
      seg_us = (q > 128'(SAT63)) ? SAT63 : q[62:0];
    endfunction

    function us_t sum_sat(us_t a, us_t b);
      logic [63:0] s;
      s = {1'b0, a} + {1'b0, b};
      sum_sat = s[63] ? SAT63 : s[62:0];
    endfunction

    // tick must already lie in 0..song_len
    function us_t micros_at_tick(longint t);
      us_t         total;
      longint      cursor;
      longint      ct;
      longint      eff;
      logic [17:0] bpm;
      total = '0;
      cursor = 0;
      bpm = DEFAULT_BPM_RAW;
      for (int i = 0; i < chg_count; i++) begin
        ct = longint'($signed(chg_tick[i]));
        if (ct > t) break;
        eff = (ct < cursor) ? cursor : ct;
        total = sum_sat(total, seg_us(longint'(eff - cursor), bpm));
        cursor = eff;
        if (chg_bpm[i] != 0) bpm = chg_bpm[i];
      end
      micros_at_tick = sum_sat(total, seg_us(longint'(t - cursor), bpm));
    endfunction

    function tick_t tick_at_micros(logic [63:0] tus);
      longint lo;
      longint hi;
      longint mid;
      lo = 0;
      hi = longint'(song_len);
      if (tus[63] || tus == 0) return '0;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if ({1'b0, micros_at_tick(mid)} < tus) lo = mid + 1;
        else hi = mid;
      end
      tick_at_micros = tick_t'(lo);
    endfunction

    function void note(logic [1:0] op, logic [31:0] tick, logic [17:0] bpm,
                       logic [63:0] tus);
      tempo_result_t r;
      longint        t;
      r = '0;
      case (op)
        OP_CLEAR: chg_count = 0;
        OP_APPEND: begin
          if (chg_count < TABLE_DEPTH) begin
            chg_tick[chg_count] = tick;
            chg_bpm[chg_count] = bpm;
            chg_count++;
          end else begin
            r.full = 1'b1;
          end
        end
        OP_T2US: begin
          t = longint'($signed(tick));
          if (t < 0) t = 0;
          if (t > longint'(song_len)) t = longint'(song_len);
          r.us = micros_at_tick(t);
        end
        default: r.tk = tick_at_micros(tus);
      endcase
      pending.insert(pending.size(), r);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      fails++;
    endtask

    task check(us_t us, tick_t tk, logic full);
      tempo_result_t e;
      if (pending.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (us !== e.us) report($sformatf("result_us %0d, expected %0d", us, e.us));
      if (tk !== e.tk) report($sformatf("result_tick %0d, expected %0d", tk, e.tk));
      if (full !== e.full) report($sformatf("table_full %0b, expected %0b", full, e.full));
    endtask
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_wr_en = 1'b0;
  logic [30:0]  cfg_wr_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [119:0] in_tdata = '0;    // event_tick, tempo_bpm, time_us
  logic [1:0]   in_tuser = '0;    // op
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [95:0]  out_tdata;        // result_us, result_tick
  logic         out_tuser;        // table_full

  tempo_map_checker tmap = new();
  longint cycles = 0;
  bit     no_gaps = 1'b0;
  logic [31:0] last_tick = '0;

  tempo_map_tick_time_convert_top #(
    .MAX_TEMPO_CHANGES(TABLE_DEPTH),
    .TICKS_PER_QUARTER(TPQ)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tempo_map_tick_time_convert_top regression: fail");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready)
      tmap.check(out_tdata[62:0], out_tdata[93:63], out_tuser);

  // result side: random stall before each word, unless no_gaps is set
  initial begin
    int w;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      w = no_gaps ? 0 : $urandom_range(0, 15);
      out_tready = 1'b0;
      repeat (w) @(negedge clk);
      out_tready = 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  task automatic send_word(logic [1:0] op, logic [31:0] tick, logic [17:0] bpm,
                           logic [63:0] tus);
    int w;
    w = no_gaps ? 0 : $urandom_range(0, 15);
    repeat (w) @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser = op;
    in_tdata = {6'b0, tus, bpm, tick};
    do @(posedge clk); while (!in_tready);
    tmap.note(op, tick, bpm, tus);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic set_song_length(logic [30:0] len);
    wait (tmap.pending.size() == 0);
    repeat (20) @(posedge clk);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = len;
    @(posedge clk);
    tmap.song_len = len;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic random_word();
    int          r;
    logic [31:0] tick;
    logic [17:0] bpm;
    logic [63:0] tus;
    longint      span;
    r = $urandom_range(0, 99);
    span = longint'(tmap.song_len);
    tick = $urandom;
    tus = {$urandom, $urandom};
    bpm = $urandom_range(0, 262143);
    if (r < 5 || (tmap.chg_count >= 8 && r < 25)) begin
      send_word(OP_CLEAR, tick, bpm, tus);
      last_tick = '0;
    end else if (r < 45) begin
      if ($urandom_range(0, 99) < 80)
        tick = last_tick + 32'($urandom_range(0, 32'(span / 4) + 1));
      case ($urandom_range(0, 3))
        0: bpm = '0;
        1: bpm = $urandom_range(15000, 60000);
        default: ;
      endcase
      last_tick = tick;
      send_word(OP_APPEND, tick, bpm, tus);
    end else if (r < 75) begin
      if ($urandom_range(0, 99) < 80) tick = $urandom_range(0, 32'(span));
      send_word(OP_T2US, tick, bpm, tus);
    end else begin
      if ($urandom_range(0, 99) < 60)
        tus = {1'b0, tmap.micros_at_tick(longint'($urandom_range(0, 32'(span))))}
              + 64'($signed($urandom_range(0, 2)) - 1);
      send_word(OP_US2T, tick, bpm, tus);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // song length still zero after reset
    send_word(OP_T2US, 32'd5, '0, '0);
    send_word(OP_US2T, '0, '0, 64'd1);
    set_song_length(31'd1000000);
    send_word(OP_T2US, 32'd480, '0, '0);          // empty table, 120 bpm
    send_word(OP_T2US, 32'h8000_0000, '0, '0);    // clamp low
    send_word(OP_T2US, 32'h7FFF_FFFF, '0, '0);    // clamp high
    send_word(OP_APPEND, 32'd0, 18'd0, '0);       // zero tempo keeps 120
    send_word(OP_APPEND, 32'd480, 18'h3FFFF, '0);
    send_word(OP_APPEND, 32'd240, 18'd15360, '0); // behind the cursor
    send_word(OP_APPEND, 32'd960, 18'd0, '0);
    send_word(OP_APPEND, 32'd2000, 18'd1, '0);
    send_word(OP_T2US, 32'd0, '0, '0);
    send_word(OP_T2US, 32'd700, '0, '0);
    send_word(OP_T2US, 32'd960, '0, '0);
    send_word(OP_T2US, 32'd1500, '0, '0);
    send_word(OP_T2US, 32'd2000000, '0, '0);
    send_word(OP_US2T, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(OP_US2T, '0, '0, 64'd0);
    send_word(OP_US2T, '0, '0, 64'd1);
    send_word(OP_US2T, '0, '0, 64'd1000000);
    send_word(OP_US2T, '0, '0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_word(OP_CLEAR, 32'hFFFF_FFFF, 18'h3FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(OP_T2US, 32'd1000, '0, '0);

    // fill the table, then one append too many
    set_song_length(31'd5000);
    no_gaps = 1'b1;
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_word(OP_APPEND, 32'(i * 70), 18'($urandom_range(1, 262143)), '0);
    send_word(OP_APPEND, 32'd9999, 18'd100, '0);
    no_gaps = 1'b0;
    send_word(OP_T2US, 32'd5000, '0, '0);
    send_word(OP_US2T, '0, '0, 64'd2000000);
    send_word(OP_CLEAR, '0, '0, '0);
    last_tick = '0;

    set_song_length(31'h7FFF_FFFF);
    for (int i = 0; i < 12; i++) random_word();
    set_song_length(31'd1);
    for (int i = 0; i < 8; i++) random_word();
    set_song_length(31'd300000);
    no_gaps = 1'b1;
    for (int i = 0; i < 12; i++) random_word();
    no_gaps = 1'b0;
    set_song_length(31'd0);
    for (int i = 0; i < 6; i++) random_word();
    set_song_length(31'd5000);
    for (int i = 0; i < 12; i++) random_word();

    wait (tmap.pending.size() == 0);
    repeat (50) @(posedge clk);
    if (tmap.fails == 0)
      $display("tempo_map_tick_time_convert_top regression: pass");
    else
      $display("tempo_map_tick_time_convert_top regression: fail");
    $finish;
  end
endmodule
